// ===== sv/feature_normalizer_macros.svh =====
// Assertion helpers used by the feature normalizer to check its own logic.
`ifndef FEATURE_NORMALIZER_MACROS_SVH
`define FEATURE_NORMALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fn_pkg.sv =====
package fn_pkg;

    localparam int MAX_SAMPLES_DEF  = 1024;
    localparam int MAX_FEATURES_DEF = 16;
    localparam int VALUE_BITS_DEF   = 32;

    localparam int SCALE_W    = 32;
    localparam int FRAC_SHIFT = 24;
    localparam int SAT_SHIFT  = 39;

    localparam logic [1:0] CMD_STORE   = 2'd0;
    localparam logic [1:0] CMD_COMPUTE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DEGEN     = 2'd1;
    localparam logic [1:0] ST_SAT       = 2'd2;
    localparam logic [1:0] ST_NOT_READY = 2'd3;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_SAMPLES  = 2'd1;
    localparam logic [1:0] CFG_FEATURES = 2'd2;

    localparam logic [1:0] MODE_MINMAX = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_WAIT,
        S_READ_DIV,
        S_READ_OUT,
        S_COL,
        S_SCAN,
        S_MEAN_DIV,
        S_VAR_SCAN,
        S_VAR_DIV,
        S_SQRT,
        S_COL_WR
    } t_state;

endpackage

// ===== sv/fn_in_if.sv =====
interface fn_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [9:0]         sample_index;
    logic [3:0]         feature_index;
    logic signed [31:0] raw_value;

    modport source (output valid, cmd, sample_index, feature_index, raw_value, input ready);
    modport sink (input valid, cmd, sample_index, feature_index, raw_value, output ready);
endinterface

// ===== sv/fn_out_if.sv =====
interface fn_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] norm_value;
    logic [1:0]         status;

    modport source (output valid, norm_value, status, input ready);
    modport sink (input valid, norm_value, status, output ready);
endinterface

// ===== sv/feature_normalizer.sv =====
// Feature normalizer. Store transactions (cmd 0) write one Q16.16 value into the
// sample memory when both indices are in range. A compute transaction (cmd 1)
// holds ready low while it walks the sample memory column by column: in min-max
// mode a used column is scanned once for its minimum and maximum, in mean and
// deviation mode it is scanned and its sum divided for the mean, then scanned
// again for the squared deviations, whose sum is divided and square-rooted. NW
// (79 at the default sizes) is the quotient width of the shared bit-serial
// divider. A read transaction (cmd 2) uses the same divider unless no division
// is needed, and its result sits in an output register so that stores may
// proceed while it waits. The sample memory has no reset and needs no clearing
// pass; reads made before the first compute return status 3.
module feature_normalizer #(
    parameter int MAX_SAMPLES  = fn_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = fn_pkg::MAX_FEATURES_DEF,
    parameter int VALUE_BITS   = fn_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    fn_in_if.sink       i_in,
    fn_out_if.source    o_out
);
    import fn_pkg::*;

    localparam int CNTW  = $clog2(MAX_SAMPLES + 1);
    localparam int FCW   = $clog2(MAX_FEATURES + 1);
    localparam int FAW   = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
    localparam int DEPTH = MAX_SAMPLES * MAX_FEATURES;
    localparam int SAW   = $clog2(DEPTH);
    localparam int OFFW  = VALUE_BITS + 1;
    localparam int DIFW  = VALUE_BITS + 2;
    localparam int SUMW  = VALUE_BITS + CNTW;
    localparam int SQW   = 2 * DIFW + CNTW;
    localparam int RDW   = DIFW + FRAC_SHIFT + 1;
    localparam int NW    = SQW > RDW ? SQW : RDW;
    localparam int VW    = NW > 64 ? NW : 64;
    localparam int STW   = OFFW + SCALE_W;

    t_state r_state, n_state;

    logic [1:0]      r_mode;
    logic [CNTW-1:0] r_n;
    logic [FCW-1:0]  r_fc;
    logic            r_stats_ready;

    logic [CNTW-1:0] r_iss;
    logic [SAW-1:0]  r_addr;
    logic [FCW-1:0]  r_col;
    logic            r_rd_v;
    logic            r_first;
    logic            r_av;
    logic            r_sqv;

    logic signed [VALUE_BITS-1:0] r_min, r_max;
    logic signed [SUMW-1:0]       r_sum;
    logic [SQW-1:0]               r_acc;
    logic [DIFW-1:0]              r_a;
    logic [2*DIFW-1:0]            r_sq;
    logic signed [OFFW-1:0]       r_off;
    logic [SCALE_W-1:0]           r_scale;
    logic [63:0]                  r_sv, r_sr, r_sbit;
    logic [5:0]                   r_scnt;

    logic            r_bad;
    logic            r_neg;
    logic [31:0]     r_res_val;
    logic [1:0]      r_res_st;
    logic            r_out_v;
    logic [31:0]     r_out_val;
    logic [1:0]      r_out_st;

    logic                  in_acc;
    logic                  ram_we;
    logic [SAW-1:0]        ram_waddr, ram_raddr, io_addr;
    logic [VALUE_BITS-1:0] ram_q;
    logic                  st_we;
    logic [FAW-1:0]        st_raddr;
    logic [STW-1:0]        st_q;
    logic                  issue;
    logic                  div_start, div_done;
    logic [NW-1:0]         div_num, div_quo;
    logic [SCALE_W-1:0]    div_den;
    logic                  load_out;

    logic signed [VALUE_BITS-1:0] x_q;
    logic signed [OFFW-1:0]       st_off;
    logic [SCALE_W-1:0]           st_scale;
    logic signed [DIFW-1:0]       rd_d, v_d;
    logic [DIFW-1:0]              rd_a, v_a;
    logic                         sum_neg;
    logic [SUMW-1:0]              sum_mag;
    logic signed [OFFW-1:0]       rng_d;
    logic [63:0]                  rng64;
    logic [VW-1:0]                q_ext;
    logic [63:0]                  var64;
    logic [63:0]                  sq_t, sq_fin;
    logic [31:0]                  cfg_v;
    logic                         scan_end;

    assign in_acc  = i_in.valid && i_in.ready;
    assign io_addr = SAW'(32'(i_in.sample_index) * MAX_FEATURES + 32'(i_in.feature_index));

    assign x_q      = $signed(ram_q);
    assign st_off   = $signed(st_q[STW-1:SCALE_W]);
    assign st_scale = st_q[SCALE_W-1:0];
    assign rd_d     = DIFW'(x_q) - DIFW'(st_off);
    assign rd_a     = rd_d[DIFW-1] ? DIFW'(-rd_d) : DIFW'(rd_d);
    assign v_d      = DIFW'(x_q) - DIFW'(r_off);
    assign v_a      = v_d[DIFW-1] ? DIFW'(-v_d) : DIFW'(v_d);
    assign sum_neg  = r_sum[SUMW-1];
    assign sum_mag  = sum_neg ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign rng_d    = OFFW'(r_max) - OFFW'(r_min);
    assign rng64    = 64'(unsigned'(rng_d));
    assign q_ext    = VW'(div_quo);
    assign var64    = (|(q_ext >> 64)) ? '1 : q_ext[63:0];
    assign sq_t     = r_sr + r_sbit;
    assign sq_fin   = (r_sv > r_sr) ? r_sr + 64'd1 : r_sr;
    assign scan_end = (r_iss == r_n) && !r_rd_v && !r_av && !r_sqv;

    fn_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_samples (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (VALUE_BITS'($unsigned(i_in.raw_value))),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    fn_ram #(.WIDTH(STW), .DEPTH(MAX_FEATURES)) u_stats (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_col[FAW-1:0]),
        .i_wdata ({r_off, r_scale}),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    fn_div #(.NW(NW), .DW(SCALE_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        n_state   = r_state;
        i_in.ready = (r_state == S_IDLE);
        ram_we    = 1'b0;
        ram_waddr = io_addr;
        ram_raddr = io_addr;
        st_raddr  = FAW'(i_in.feature_index);
        st_we     = 1'b0;
        issue     = 1'b0;
        div_start = 1'b0;
        div_num   = NW'(sum_mag) + NW'(r_n >> 1);
        div_den   = SCALE_W'(r_n);
        load_out  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.cmd)
                        CMD_STORE: begin
                            ram_we = (32'(i_in.sample_index) < MAX_SAMPLES) &&
                                     (32'(i_in.feature_index) < MAX_FEATURES);
                        end
                        CMD_COMPUTE: n_state = S_COL;
                        CMD_READ:    n_state = S_READ_WAIT;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_READ_WAIT: begin
                div_num = (NW'(rd_a) << FRAC_SHIFT) + NW'(st_scale >> 1);
                div_den = st_scale;
                if (r_bad || st_scale == '0 || 64'(rd_a) >= (64'd1 << SAT_SHIFT)) begin
                    n_state = S_READ_OUT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_READ_DIV;
                end
            end
            S_READ_DIV: begin
                if (div_done) begin
                    n_state = S_READ_OUT;
                end
            end
            S_READ_OUT: begin
                if (!r_out_v || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_COL: begin
                if (r_col == FCW'(MAX_FEATURES)) begin
                    n_state = S_IDLE;
                end else if (r_col >= r_fc) begin
                    n_state = S_COL_WR;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                ram_raddr = r_addr;
                issue     = (r_iss != r_n);
                if (scan_end) begin
                    if (r_mode == MODE_MINMAX) begin
                        n_state = S_COL_WR;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_MEAN_DIV;
                    end
                end
            end
            S_MEAN_DIV: begin
                if (div_done) begin
                    n_state = S_VAR_SCAN;
                end
            end
            S_VAR_SCAN: begin
                ram_raddr = r_addr;
                issue     = (r_iss != r_n);
                div_num   = NW'(r_acc);
                div_den   = SCALE_W'(r_n) - SCALE_W'(1);
                if (scan_end) begin
                    div_start = 1'b1;
                    n_state   = S_VAR_DIV;
                end
            end
            S_VAR_DIV: begin
                if (div_done) begin
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                if (r_scnt == 6'd32) begin
                    n_state = S_COL_WR;
                end
            end
            S_COL_WR: begin
                st_we   = 1'b1;
                n_state = S_COL;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        cfg_v = 32'(i_cfg_data);
        if (i_cfg_index == CFG_SAMPLES) begin
            if (cfg_v < 32'd2) cfg_v = 32'd2;
            if (cfg_v > 32'(MAX_SAMPLES)) cfg_v = 32'(MAX_SAMPLES);
        end else begin
            cfg_v = 32'(i_cfg_data[4:0]);
            if (cfg_v < 32'd1) cfg_v = 32'd1;
            if (cfg_v > 32'(MAX_FEATURES)) cfg_v = 32'(MAX_FEATURES);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 2'd1;
            r_n           <= CNTW'(2);
            r_fc          <= FCW'(1);
            r_stats_ready <= 1'b0;
            r_rd_v        <= 1'b0;
            r_av          <= 1'b0;
            r_sqv         <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MODE:     r_mode <= i_cfg_data[1:0];
                    CFG_SAMPLES:  r_n    <= CNTW'(cfg_v);
                    CFG_FEATURES: r_fc   <= FCW'(cfg_v);
                    default:      r_mode <= r_mode;
                endcase
            end
            if (r_state == S_COL && r_col == FCW'(MAX_FEATURES)) begin
                r_stats_ready <= 1'b1;
            end
            r_rd_v <= issue;
            r_av   <= r_rd_v && (r_state == S_VAR_SCAN);
            r_sqv  <= r_av;
            if (load_out) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.cmd == CMD_COMPUTE) begin
            r_col <= '0;
        end
        if (in_acc) begin
            r_bad <= !r_stats_ready || (32'(i_in.sample_index) >= 32'(r_n)) ||
                     (32'(i_in.feature_index) >= 32'(r_fc));
        end
        if (issue) begin
            r_iss  <= r_iss + CNTW'(1);
            r_addr <= r_addr + SAW'(MAX_FEATURES);
        end
        r_a  <= v_a;
        r_sq <= (2*DIFW)'(r_a) * (2*DIFW)'(r_a);
        if (r_sqv) begin
            r_acc <= r_acc + SQW'(r_sq);
        end
        case (r_state)
            S_COL: begin
                r_iss   <= '0;
                r_addr  <= SAW'(r_col);
                r_first <= 1'b1;
                r_sum   <= '0;
                r_acc   <= '0;
                r_off   <= '0;
                r_scale <= '0;
            end
            S_SCAN: begin
                if (r_rd_v) begin
                    r_first <= 1'b0;
                    r_sum   <= r_sum + SUMW'(x_q);
                    if (r_first || x_q < r_min) r_min <= x_q;
                    if (r_first || x_q > r_max) r_max <= x_q;
                end
                if (scan_end) begin
                    r_off   <= OFFW'(r_min);
                    r_scale <= (rng64 > 64'hFFFF_FFFF) ? '1 : rng64[31:0];
                end
            end
            S_MEAN_DIV: begin
                r_iss  <= '0;
                r_addr <= SAW'(r_col);
                if (div_done) begin
                    r_off <= sum_neg ? -$signed(div_quo[OFFW-1:0]) : $signed(div_quo[OFFW-1:0]);
                end
            end
            S_VAR_DIV: begin
                r_sv   <= var64;
                r_sr   <= '0;
                r_sbit <= 64'd1 << 62;
                r_scnt <= '0;
            end
            S_SQRT: begin
                if (r_scnt == 6'd32) begin
                    r_scale <= (sq_fin > 64'hFFFF_FFFF) ? '1 : sq_fin[31:0];
                end else begin
                    r_scnt <= r_scnt + 6'd1;
                    r_sbit <= r_sbit >> 2;
                    if (r_sv >= sq_t) begin
                        r_sv <= r_sv - sq_t;
                        r_sr <= (r_sr >> 1) + r_sbit;
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                end
            end
            S_COL_WR: r_col <= r_col + FCW'(1);
            S_READ_WAIT: begin
                r_neg     <= rd_d[DIFW-1];
                r_res_val <= rd_d[DIFW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                r_res_st  <= ST_SAT;
                if (r_bad) begin
                    r_res_val <= '0;
                    r_res_st  <= ST_NOT_READY;
                end else if (st_scale == '0) begin
                    r_res_val <= '0;
                    r_res_st  <= ST_DEGEN;
                end
            end
            S_READ_DIV: begin
                if (div_done) begin
                    if (!r_neg) begin
                        if (q_ext > VW'(32'h7FFF_FFFF)) begin
                            r_res_val <= 32'h7FFF_FFFF;
                            r_res_st  <= ST_SAT;
                        end else begin
                            r_res_val <= q_ext[31:0];
                            r_res_st  <= ST_OK;
                        end
                    end else begin
                        if (q_ext > VW'(32'h8000_0000)) begin
                            r_res_val <= 32'h8000_0000;
                            r_res_st  <= ST_SAT;
                        end else begin
                            r_res_val <= ~q_ext[31:0] + 32'd1;
                            r_res_st  <= ST_OK;
                        end
                    end
                end
            end
            default: r_first <= r_first;
        endcase
        if (load_out) begin
            r_out_val <= r_res_val;
            r_out_st  <= r_res_st;
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.norm_value = $signed(r_out_val);
    assign o_out.status     = r_out_st;

`include "feature_normalizer_macros.svh"

    `FN_ASSERT_NXT(a_read_lookup, i_clk, i_rst_n, in_acc && i_in.cmd == CMD_READ, r_state == S_READ_WAIT, "read transaction did not start a lookup")
    `FN_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_done, r_state == S_READ_DIV || r_state == S_MEAN_DIV || r_state == S_VAR_DIV, "divider finished with no consumer")
    `FN_ASSERT_NXT(a_stats_sticky, i_clk, i_rst_n, r_stats_ready, r_stats_ready, "statistics ready flag dropped")
    `FN_ASSERT_NXT(a_result_held, i_clk, i_rst_n, r_state == S_READ_OUT && r_out_v && !o_out.ready, r_state == S_READ_OUT, "read result left before output register was free")

endmodule

// ===== sv/fn_ram.sv =====
module fn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/fn_div.sv =====
module fn_div #(
    parameter int NW = 80,
    parameter int DW = fn_pkg::SCALE_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_num;
    logic [DW:0]   rem_s;
    logic [DW:0]   rem_d;
    logic          qbit;

    always_comb begin
        rem_s = {r_rem, r_num[NW-1]};
        qbit  = (rem_s >= {1'b0, r_den});
        rem_d = qbit ? (rem_s - {1'b0, r_den}) : rem_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_cnt <= '0;
            r_rem <= '0;
            r_den <= i_den;
            r_num <= i_num;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            r_rem <= rem_d[DW-1:0];
            r_num <= {r_num[NW-2:0], qbit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule
